// ===== rtl/gf2_poly_irreducibility_test_defines.svh =====
// Assertion macros for the irreducibility test checker
`ifndef GF2_POLY_IRREDUCIBILITY_TEST_DEFINES_SVH
`define GF2_POLY_IRREDUCIBILITY_TEST_DEFINES_SVH
`define GPIT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: lbl");
`define GPIT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`endif

// ===== rtl/gpit_pkg.sv =====
`default_nettype none
package gpit_pkg;
  localparam int unsigned PolyW = 64;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_SQ_INIT,
    DP_SQ_STEP,
    DP_REM_INIT,
    DP_REM_STEP,
    DP_GCD_INIT,
    DP_GCD_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       trivial_red;
    logic       no_rounds;
    logic       last_round;
    logic       step_done;
    logic       gcd_done;
    logic       gcd_is_one;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/gf2_poly_irreducibility_test.sv =====
// Ben-Or irreducibility test over GF(2), one polynomial at a time.
// Zero, 1, x and x+1 are decided in the check state; otherwise up to floor(deg/2) rounds
// of squaring, reduction and control plus a bit-serial gcd, ending early on a gcd not 1.
// A new request is taken only while idle (busy low); done_o pulses one cycle, cannot stall.
// rst_ni is asynchronous, active low; returns to idle with no result pending.
`default_nettype none
module gf2_poly_irreducibility_test #(
  parameter int unsigned MAX_DEGREE = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] poly_bits_i,
  output logic             done_o,
  output logic             reducible_o
);
  gpit_pkg::dp_cmd_t cmd;
  gpit_pkg::dp_sts_t sts;

  gpit_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .done_o, .reducible_o
  );

  gpit_datapath #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk_i, .rst_ni, .poly_bits_i, .cmd_i(cmd), .sts_o(sts)
  );
endmodule
`default_nettype wire

// ===== rtl/gpit_datapath.sv =====
`default_nettype none
module gpit_datapath #(
  parameter int unsigned MAX_DEGREE = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [63:0]       poly_bits_i,
  input  wire gpit_pkg::dp_cmd_t cmd_i,
  output gpit_pkg::dp_sts_t      sts_o
);
  localparam logic [63:0] Mask = {64{1'b1}} >> (63 - MAX_DEGREE);

  logic [63:0] modulus_q, modulus_d;
  logic [63:0] power_q, power_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] gcd_left_q, gcd_left_d;
  logic [63:0] gcd_right_q, gcd_right_d;
  logic [5:0]  round_index_q, round_index_d;
  logic [5:0]  deg_q, deg_d;
  logic [5:0]  bit_q, bit_d;

  logic [63:0] f_in;
  logic [5:0]  f_deg;
  logic [5:0]  r_deg;
  logic [63:0] sq_sh;
  logic [63:0] sq_nx;

  // priority encoders for degree of the loaded word and of the gcd right operand
  always_comb begin
    f_in  = poly_bits_i & Mask;
    f_deg = '0;
    for (int k = 0; k < 64; k++) begin
      if (f_in[k]) f_deg = 6'(k);
    end
    r_deg = '0;
    for (int k = 0; k < 64; k++) begin
      if (gcd_right_q[k]) r_deg = 6'(k);
    end
  end

  // one mulmod step: shift, reduce, conditional add
  always_comb begin
    sq_sh = acc_q << 1;
    if (sq_sh[deg_q]) sq_sh = sq_sh ^ modulus_q;
    sq_nx = power_q[bit_q] ? (sq_sh ^ power_q) : sq_sh;
  end

  always_comb begin
    modulus_d     = modulus_q;
    power_d       = power_q;
    acc_d         = acc_q;
    gcd_left_d    = gcd_left_q;
    gcd_right_d   = gcd_right_q;
    round_index_d = round_index_q;
    deg_d         = deg_q;
    bit_d         = bit_q;
    unique case (cmd_i.op)
      gpit_pkg::DP_LOAD: begin
        modulus_d     = f_in;
        deg_d         = f_deg;
        power_d       = 64'd2;
        round_index_d = '0;
      end
      gpit_pkg::DP_SQ_INIT: begin
        acc_d         = '0;
        bit_d         = 6'd63;
        round_index_d = round_index_q + 6'd1;
      end
      gpit_pkg::DP_SQ_STEP: begin
        acc_d = sq_nx;
        bit_d = bit_q - 6'd1;
        if (bit_q == '0) power_d = sq_nx;
      end
      gpit_pkg::DP_REM_INIT: begin
        // power is reduced, so power^x has degree < deg unless deg == 1
        acc_d = power_q ^ 64'd2;
        bit_d = 6'd63;
      end
      gpit_pkg::DP_REM_STEP: begin
        if (bit_q >= deg_q && acc_q[bit_q]) acc_d = acc_q ^ (modulus_q << (bit_q - deg_q));
        bit_d = bit_q - 6'd1;
      end
      gpit_pkg::DP_GCD_INIT: begin
        gcd_left_d  = modulus_q;
        gcd_right_d = acc_q;
        bit_d       = 6'd63;
      end
      gpit_pkg::DP_GCD_STEP: begin
        // reduce left by right one bit per cycle, then swap
        if (bit_q >= r_deg && gcd_left_q[bit_q])
          gcd_left_d = gcd_left_q ^ (gcd_right_q << (bit_q - r_deg));
        if (bit_q == r_deg) begin
          gcd_left_d  = gcd_right_q;
          gcd_right_d = gcd_left_q[bit_q] ?
                        (gcd_left_q ^ gcd_right_q) : gcd_left_q;
          bit_d       = r_deg;
        end else begin
          bit_d = bit_q - 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= '0;
      power_q       <= '0;
      gcd_left_q    <= '0;
      gcd_right_q   <= '0;
      round_index_q <= '0;
      deg_q         <= '0;
      bit_q         <= '0;
      acc_q         <= '0;
    end else begin
      modulus_q     <= modulus_d;
      power_q       <= power_d;
      gcd_left_q    <= gcd_left_d;
      gcd_right_q   <= gcd_right_d;
      round_index_q <= round_index_d;
      deg_q         <= deg_d;
      bit_q         <= bit_d;
      acc_q         <= acc_d;
    end
  end

  assign sts_o.trivial_red = (modulus_q == 64'd1) || (modulus_q == 64'd2);
  assign sts_o.no_rounds   = (deg_q < 6'd2);
  assign sts_o.last_round  = (round_index_q == {1'b0, deg_q[5:1]});
  assign sts_o.step_done   = (bit_q == '0);
  assign sts_o.gcd_done    = (gcd_right_q == '0);
  assign sts_o.gcd_is_one  = (gcd_left_q == 64'd1);
endmodule
`default_nettype wire

// ===== rtl/gpit_ctrl.sv =====
`default_nettype none
module gpit_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire gpit_pkg::dp_sts_t sts_i,
  output gpit_pkg::dp_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o,
  output logic                   reducible_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SQ_INIT, S_SQ, S_REM_INIT, S_REM, S_GCD_INIT, S_GCD, S_EVAL
  } state_e;

  state_e state_q;
  logic   done_q, red_q;

  always_comb begin
    unique case (state_q)
      S_IDLE:     cmd_o.op = start_i ? gpit_pkg::DP_LOAD : gpit_pkg::DP_NOP;
      S_SQ_INIT:  cmd_o.op = gpit_pkg::DP_SQ_INIT;
      S_SQ:       cmd_o.op = gpit_pkg::DP_SQ_STEP;
      S_REM_INIT: cmd_o.op = gpit_pkg::DP_REM_INIT;
      S_REM:      cmd_o.op = gpit_pkg::DP_REM_STEP;
      S_GCD_INIT: cmd_o.op = gpit_pkg::DP_GCD_INIT;
      S_GCD:      cmd_o.op = sts_i.gcd_done ? gpit_pkg::DP_NOP : gpit_pkg::DP_GCD_STEP;
      default:    cmd_o.op = gpit_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      red_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_CHECK;
        S_CHECK: begin
          if (sts_i.trivial_red || sts_i.no_rounds) begin
            red_q   <= sts_i.trivial_red;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SQ_INIT;
          end
        end
        S_SQ_INIT:  state_q <= S_SQ;
        S_SQ:       if (sts_i.step_done) state_q <= S_REM_INIT;
        S_REM_INIT: state_q <= S_REM;
        S_REM:      if (sts_i.step_done) state_q <= S_GCD_INIT;
        S_GCD_INIT: state_q <= S_GCD;
        S_GCD:      if (sts_i.gcd_done) state_q <= S_EVAL;
        S_EVAL: begin
          if (!sts_i.gcd_is_one || sts_i.last_round) begin
            red_q   <= !sts_i.gcd_is_one;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SQ_INIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign reducible_o = red_q;
endmodule
`default_nettype wire

// ===== rtl/gpit_checker.sv =====
`default_nettype none
`include "gf2_poly_irreducibility_test_defines.svh"
module gpit_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);
  `GPIT_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `GPIT_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o)
  `GPIT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy)
  `GPIT_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> (!busy && !done_o) || !rst_ni)
endmodule

bind gf2_poly_irreducibility_test gpit_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] poly_bits_i;
  logic        done_o;
  logic        reducible_o;

  localparam int unsigned MaxDegree = 63;
  localparam longint unsigned CycleLimit = 10000000;

  bit     verdict_q[$];
  int     n_fail;
  longint unsigned n_cycle;
  int     idle_pct;

  gf2_poly_irreducibility_test #(.MAX_DEGREE(MaxDegree)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .poly_bits_i (poly_bits_i),
    .done_o      (done_o),
    .reducible_o (reducible_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int deg_of(logic [63:0] a);
    for (int k = 63; k >= 0; k--) begin
      if (a[k]) return k;
    end
    return -1;
  endfunction

  function automatic logic [63:0] rem_of(logic [63:0] a, logic [63:0] m);
    int dm;
    dm = deg_of(m);
    if (dm < 0) return a;
    for (int k = 63; k >= dm; k--) begin
      if (a[k]) a = a ^ (m << (k - dm));
    end
    return a;
  endfunction

  function automatic logic [63:0] sqmod(logic [63:0] a, logic [63:0] f, int df);
    logic [63:0] acc;
    acc = '0;
    for (int k = 63; k >= 0; k--) begin
      acc = acc << 1;
      if (acc[df]) acc = acc ^ f;
      if (a[k]) acc = acc ^ a;
    end
    return acc;
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = rem_of(a, b);
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit predict_reducible(logic [63:0] raw);
    logic [63:0] f, pw, b;
    int d;
    f = raw & ({64{1'b1}} >> (63 - MaxDegree));
    if (f == 64'd1 || f == 64'd2) return 1'b1;
    d = deg_of(f);
    pw = 64'd2;
    for (int i = 1; i <= d / 2; i++) begin
      pw = sqmod(pw, f, d);
      b = rem_of(pw ^ 64'd2, f);
      if (gcd_of(f, b) != 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_poly(logic [63:0] p);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start = 1'b1;
    poly_bits_i = p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    verdict_q.insert(verdict_q.size(), predict_reducible(p));
    @(negedge clk_i);
    start = 1'b0;
    poly_bits_i = {$urandom, $urandom};
  endtask

  always @(posedge clk_i) begin
    n_cycle <= n_cycle + 1;
    if (n_cycle > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: reducible actual %0b", reducible_o);
        n_fail++;
      end else begin
        if (reducible_o !== verdict_q[0]) begin
          $error("reducible: expected %0b actual %0b", verdict_q[0], reducible_o);
          n_fail++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  function automatic logic [63:0] rand_poly();
    logic [63:0] p;
    int d;
    p = {$urandom, $urandom};
    case ($urandom_range(3))
      0: d = $urandom_range(2, 10);
      1: d = $urandom_range(11, 30);
      default: d = $urandom_range(31, 63);
    endcase
    if (d < 63) p = p & ((64'd1 << (d + 1)) - 1);
    p[d] = 1'b1;
    if ($urandom_range(1)) p[0] = 1'b1;
    return p;
  endfunction

  task automatic test_trivial();
    send_poly(64'd0);
    send_poly(64'd1);
    send_poly(64'd2);
    send_poly(64'd3);
  endtask

  task automatic test_small_known();
    send_poly(64'h7);
    send_poly(64'h5);
    send_poly(64'hB);
    send_poly(64'hF);
    send_poly(64'h13);
    send_poly(64'h11B);
    send_poly(64'h11D);
  endtask

  task automatic test_extremes();
    send_poly({64{1'b1}});
    send_poly(64'h8000_0000_0000_0000);
    send_poly(64'h8000_0000_0000_001B);
    send_poly(64'h8000_0000_0000_0001);
    send_poly(64'hAAAA_AAAA_AAAA_AAAA);
    send_poly(64'h5555_5555_5555_5555);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i < n / 3) idle_pct = 8;
      else if (i < 2 * n / 3) idle_pct = 88;
      else idle_pct = 0;
      send_poly(rand_poly());
    end
  endtask

  initial begin
    n_fail = 0;
    n_cycle = 0;
    idle_pct = 8;
    rst_ni = 1'b0;
    start = 1'b0;
    poly_bits_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_trivial();
    test_small_known();
    test_extremes();
    test_random(123);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/gpit_pkg.sv
rtl/gpit_datapath.sv
rtl/gpit_ctrl.sv
rtl/gf2_poly_irreducibility_test.sv
rtl/gpit_checker.sv
tb/sv/testbench.sv
